### design/rnrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rnrq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef logic [1:0] op_t;
  localparam op_t OP_POST = 2'd0;
  localparam op_t OP_ACK  = 2'd1;
  localparam op_t OP_TICK = 2'd2;

  typedef enum logic [1:0] {
    KIND_NEW    = 2'd0,
    KIND_RESEND = 2'd1,
    KIND_DROP   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]  msg_type;
    logic [15:0] spec;
    logic [31:0] pid;
    logic [31:0] ctx;
  } entry_t;

  typedef struct packed {
    op_t    op;
    entry_t ent;
    logic   force_req;
  } req_t;

  // controller -> datapath
  typedef struct packed {
    logic  latch;      // capture input word
    logic  rd_en;      // registered read of the queue
    logic  rd_search;  // read at head + idx, else at head
    logic  idx_clr;
    logic  idx_inc;
    logic  append;     // write at tail, count + 1
    logic  force_wr;   // write at head, count = 1, not awaiting
    logic  pop;        // head + 1, count - 1, not awaiting
    logic  arm;        // retry = max_retries (1 if zero), seq + 1
    logic  tick;       // retry - 1
    logic  clear;      // count = 0
    logic  emit;       // load output register
    kind_t kind;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic force_req;
    logic count_zero;
    logic count_one;
    logic full;
    logic retry_zero;
    logic retry_one;
    logic idx_done;
    logic match;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

### design/rnrq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rnrq_ctrl (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_stall,
  input  rnrq_pkg::stat_t stat,
  output rnrq_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_SRCH_RD  = 7'b0000100,
    S_SRCH_CMP = 7'b0001000,
    S_APPEND   = 7'b0010000,
    S_SEND     = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  rnrq_pkg::kind_t kind_r, kind_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (stat.op == rnrq_pkg::OP_POST) begin
          if (stat.force_req) begin
            cmd.force_wr = 1'b1;
            state_nxt    = S_SEND;
          end else begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_SRCH_RD;
          end
        end else if (stat.op == rnrq_pkg::OP_ACK) begin
          if (stat.count_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.pop   = 1'b1;
            state_nxt = stat.count_one ? S_IDLE : S_SEND;
          end
        end else if (stat.op == rnrq_pkg::OP_TICK) begin
          if (stat.retry_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.tick = 1'b1;
            if (stat.retry_one) begin
              cmd.clear = 1'b1;
              kind_nxt  = rnrq_pkg::KIND_DROP;
            end else begin
              cmd.rd_en = 1'b1;
              kind_nxt  = rnrq_pkg::KIND_RESEND;
            end
            state_nxt = S_EMIT;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SRCH_RD: begin
        if (stat.idx_done) begin
          state_nxt = S_APPEND;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_search = 1'b1;
          state_nxt     = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (stat.match) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SRCH_RD;
        end
      end
      S_APPEND: begin
        if (stat.full) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.append = 1'b1;
          state_nxt  = S_SEND;
        end
      end
      S_SEND: begin
        if (stat.retry_zero && !stat.count_zero) begin
          cmd.arm   = 1'b1;
          cmd.rd_en = 1'b1;
          kind_nxt  = rnrq_pkg::KIND_NEW;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= rnrq_pkg::KIND_NEW;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule
`default_nettype wire

### design/rnrq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module rnrq_dp (
  input  wire                   clk,
  input  wire                   rst_n,
  input  rnrq_pkg::cmd_t        cmd,
  output rnrq_pkg::stat_t       stat,
  input  wire                   cfg_wr_en,
  input  wire  [7:0]            cfg_max_retries,
  input  rnrq_pkg::req_t        in_word,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [1:0]            out_event_kind,
  output logic [7:0]            out_type,
  output logic [31:0]           out_sequence_res,
  output logic [15:0]           out_spec,
  output logic [31:0]           out_pid,
  output logic [31:0]           out_context
);

  localparam int DEPTH = rnrq_pkg::QUEUE_DEPTH;
  localparam int CNT_W = rnrq_pkg::CNT_W;
  localparam int PTR_W = rnrq_pkg::PTR_W;
  localparam int SUM_W = CNT_W + 1;

  rnrq_pkg::entry_t mem [DEPTH];
  rnrq_pkg::entry_t rd_data_r;
  rnrq_pkg::req_t   in_r;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [7:0]       retry_r, retry_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [7:0]       max_retries_r;
  logic             out_valid_r;

  logic [PTR_W-1:0] search_addr, tail_addr, head_inc, rd_addr, wr_addr;

  // head + offset modulo depth; the sum stays below twice the depth
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) sum = sum - SUM_W'(DEPTH);
    return sum[PTR_W-1:0];
  endfunction

  assign search_addr = wrap_add(head_r, idx_r);
  assign tail_addr   = wrap_add(head_r, count_r);
  assign head_inc    = wrap_add(head_r, CNT_W'(1));
  assign rd_addr     = cmd.rd_search ? search_addr : head_r;
  assign wr_addr     = cmd.append ? tail_addr : head_r;

  always_ff @(posedge clk) begin
    if (cmd.append || cmd.force_wr) mem[wr_addr] <= in_r.ent;
    if (cmd.rd_en) rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    retry_nxt = retry_r;
    seq_nxt   = seq_r;
    idx_nxt   = idx_r;
    priority if (cmd.force_wr) begin
      count_nxt = CNT_W'(1);
      retry_nxt = '0;
    end else if (cmd.append) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      head_nxt  = head_inc;
      count_nxt = count_r - CNT_W'(1);
      retry_nxt = '0;
    end else if (cmd.arm) begin
      retry_nxt = (max_retries_r == 8'd0) ? 8'd1 : max_retries_r;
      seq_nxt   = seq_r + 32'd1;
    end else if (cmd.tick) begin
      retry_nxt = retry_r - 8'd1;
      if (cmd.clear) count_nxt = '0;
    end else begin
      head_nxt = head_r;
    end
    priority if (cmd.idx_clr) idx_nxt = '0;
    else if (cmd.idx_inc) idx_nxt = idx_r + CNT_W'(1);
    else idx_nxt = idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      count_r       <= '0;
      retry_r       <= '0;
      seq_r         <= '0;
      idx_r         <= '0;
      max_retries_r <= 8'd30;
      out_valid_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      retry_r <= retry_nxt;
      seq_r   <= seq_nxt;
      idx_r   <= idx_nxt;
      if (cfg_wr_en) max_retries_r <= cfg_max_retries;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) in_r <= in_word;
    if (cmd.emit) begin
      out_event_kind <= cmd.kind;
      if (cmd.kind == rnrq_pkg::KIND_DROP) begin
        out_type         <= '0;
        out_sequence_res <= '0;
        out_spec         <= '0;
        out_pid          <= '0;
        out_context      <= '0;
      end else begin
        out_type         <= rd_data_r.msg_type;
        out_sequence_res <= seq_r;
        out_spec         <= rd_data_r.spec;
        out_pid          <= rd_data_r.pid;
        out_context      <= rd_data_r.ctx;
      end
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    stat.op         = in_r.op;
    stat.force_req  = in_r.force_req;
    stat.count_zero = (count_r == '0);
    stat.count_one  = (count_r == CNT_W'(1));
    stat.full       = (count_r >= CNT_W'(DEPTH));
    stat.retry_zero = (retry_r == 8'd0);
    stat.retry_one  = (retry_r == 8'd1);
    stat.idx_done   = (idx_r == count_r);
    stat.match      = (rd_data_r.msg_type == in_r.ent.msg_type) &&
                      (rd_data_r.pid == in_r.ent.pid);
    stat.out_busy   = out_valid_r && out_stall;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_await_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    retry_r != 8'd0 |-> count_r != '0)
    else $error("awaiting ack with empty queue");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  a_drop_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.kind == rnrq_pkg::KIND_DROP |-> count_r == '0 && retry_r == 8'd0)
    else $error("drop reported with queue still live");

endmodule
`default_nettype wire

### design/reliable_notify_retry_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   op, msg_type, spec, pid, context_req, force_req
// out      output     out_valid/out_stall event_kind, type, sequence_res, spec, pid, context
// cfg      input      cfg_wr_en           max_retries (8 bit)
//
// One word at a time: a new word is accepted only while the sequencer is idle. A post
// without force_req runs a duplicate search that reads the queued entries one at a time
// and appends only if it finds no match and the queue is not full.
// Reset (rst_n low, synchronous) clears count, wait and sequence; max_retries goes to 30.
// A result sits in an output register; the next word is accepted while it is stalled,
// and only a further result waits until out_stall drops.
module reliable_notify_retry_queue (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_max_retries,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_op,
  input  wire  [7:0]  in_msg_type,
  input  wire  [15:0] in_spec,
  input  wire  [31:0] in_pid,
  input  wire  [31:0] in_context_req,
  input  wire         in_force_req,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_type,
  output logic [31:0] out_sequence_res,
  output logic [15:0] out_spec,
  output logic [31:0] out_pid,
  output logic [31:0] out_context
);

  rnrq_pkg::cmd_t  cmd;
  rnrq_pkg::stat_t stat;
  rnrq_pkg::req_t  in_word;

  // input word bundled for capture in the datapath
  always_comb begin
    in_word.op           = in_op;
    in_word.ent.msg_type = in_msg_type;
    in_word.ent.spec     = in_spec;
    in_word.ent.pid      = in_pid;
    in_word.ent.ctx      = in_context_req;
    in_word.force_req    = in_force_req;
  end

  // sequencer: dispatch, duplicate search, append, send, emit
  rnrq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // circular queue memory, counters, sequence number, output register
  rnrq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_max_retries  (cfg_max_retries),
    .in_word          (in_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_type         (out_type),
    .out_sequence_res (out_sequence_res),
    .out_spec         (out_spec),
    .out_pid          (out_pid),
    .out_context      (out_context)
  );

endmodule
`default_nettype wire
